/* rtl/core/ile_pkg.sv */
// Shared definitions for the indexed list engine: field widths, operation
// and status codes, and the command/status bundles between controller and
// datapath. No dependencies.
package ile_pkg;

  localparam int CAPACITY_DEFAULT = 1024;

  localparam int OP_W  = 4;
  localparam int VAL_W = 32;
  localparam int POS_W = 16;
  localparam int FP_W  = 12;
  localparam int LEN_W = 11;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd0;
  localparam logic [OP_W-1:0] OP_APPEND    = 4'd1;
  localparam logic [OP_W-1:0] OP_PREPEND   = 4'd2;
  localparam logic [OP_W-1:0] OP_INSERT    = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK  = 4'd4;
  localparam logic [OP_W-1:0] OP_POP_FRONT = 4'd5;
  localparam logic [OP_W-1:0] OP_REMOVE    = 4'd6;
  localparam logic [OP_W-1:0] OP_MEMBER    = 4'd7;
  localparam logic [OP_W-1:0] OP_GET       = 4'd8;
  localparam logic [OP_W-1:0] OP_FIND      = 4'd9;
  localparam logic [OP_W-1:0] OP_LENGTH    = 4'd10;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Read pointer update
  typedef enum logic [2:0] {
    RP_HOLD,
    RP_TOP,
    RP_IDX,
    RP_ZERO,
    RP_INC,
    RP_DEC
  } rp_sel_e;

  typedef struct packed {
    logic            ld_req;   // capture the request, clear the work result
    logic            cnt_clr;
    logic            cnt_inc;
    logic            cnt_dec;
    rp_sel_e         rp_op;
    logic            rd;       // read entry at the pointer
    logic            wr_pend;  // write back the entry read last cycle
    logic            dir_up;   // pending write goes one place up (else down)
    logic            wr_val;   // write the request value at the target index
    logic            st_set;
    logic [ST_W-1:0] st_val;
    logic            rv_neg;
    logic            grab;     // take read data as the result value
    logic            mem_hit;
    logic            fp_hit;
    logic            fp_miss;
    logic            out_load;
  } ile_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            ins_bad;
    logic            rem_bad;
    logic            at_end;       // target index equals the length
    logic            more;         // pointer below the length
    logic            rp_next_end;  // pointer is the last entry
    logic            rp_at_idx;
    logic            pend;
    logic            match;
    logic            out_free;
  } ile_stat_t;

endpackage

/* rtl/core/ile_dp.sv */
// Datapath of the indexed list engine: entry memory, length counter, read
// pointer, work result and output register. Depends on ile_pkg.
module ile_dp import ile_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ile_cmd_t                cmd_i,
  output ile_stat_t               stat_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [VAL_W-1:0]        item_value_i,
  input  logic [POS_W-1:0]        position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] result_value_o,
  output logic signed [FP_W-1:0]  found_position_o,
  output logic                    is_member_o,
  output logic [LEN_W-1:0]        entry_count_o,
  output logic [ST_W-1:0]         status_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rp_q, rp_d;
  logic [CW-1:0] tag_q;
  logic          pend_q;
  logic [CW-1:0] idx_w;

  logic [VAL_W-1:0] res_rv_q;
  logic [FP_W-1:0]  res_fp_q;
  logic             res_mem_q;
  logic [ST_W-1:0]  res_st_q;

  logic             out_valid_q;
  logic [VAL_W-1:0] out_rv_q;
  logic [FP_W-1:0]  out_fp_q;
  logic             out_mem_q;
  logic [LEN_W-1:0] out_len_q;
  logic [ST_W-1:0]  out_st_q;

  logic [XW-1:0]    pos_x, cnt_x;
  logic [CW-1:0]    wa_w;
  logic [VAL_W-1:0] wd_w;
  logic [31:0]      cnt32, hit32;

  // Target index of the current request
  always_comb begin
    case (op_q)
      OP_APPEND:                idx_w = cnt_q;
      OP_PREPEND, OP_POP_FRONT: idx_w = '0;
      OP_POP_BACK:              idx_w = cnt_q - 1'b1;
      OP_INSERT, OP_REMOVE, OP_GET: idx_w = CW'(pos_q - 16'd1);
      default:                  idx_w = '0;
    endcase
  end

  assign pos_x = XW'(pos_q);
  assign cnt_x = XW'(cnt_q);

  always_comb begin
    stat_o.op          = op_q;
    stat_o.full        = (cnt_q == CW'(CAPACITY));
    stat_o.empty       = (cnt_q == '0);
    stat_o.ins_bad     = (pos_q == '0) || (pos_x > cnt_x + 1'b1);
    stat_o.rem_bad     = (pos_q == '0) || (pos_x > cnt_x);
    stat_o.at_end      = (idx_w == cnt_q);
    stat_o.more        = (rp_q < cnt_q);
    stat_o.rp_next_end = (CW'(rp_q + 1'b1) == cnt_q);
    stat_o.rp_at_idx   = (rp_q == idx_w);
    stat_o.pend        = pend_q;
    stat_o.match       = (rdata_q == val_q);
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    case (cmd_i.rp_op)
      RP_TOP:  rp_d = cnt_q - 1'b1;
      RP_IDX:  rp_d = idx_w;
      RP_ZERO: rp_d = '0;
      RP_INC:  rp_d = rp_q + 1'b1;
      RP_DEC:  rp_d = rp_q - 1'b1;
      default: rp_d = rp_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Single write port: either the request value or the shifted entry
  always_comb begin
    if (cmd_i.wr_val) begin
      wa_w = idx_w;
      wd_w = val_q;
    end else begin
      wa_w = cmd_i.dir_up ? CW'(tag_q + 1'b1) : CW'(tag_q - 1'b1);
      wd_w = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_val || cmd_i.wr_pend) begin
      mem_q[wa_w[AW-1:0]] <= wd_w;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rp_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= cmd_i.rd;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cnt32 = 32'(cnt_q);
  assign hit32 = 32'(tag_q) + 32'd1;

  always_ff @(posedge clk_i) begin
    rp_q <= rp_d;
    if (cmd_i.rd) begin
      tag_q <= rp_q;
    end
    if (cmd_i.ld_req) begin
      op_q      <= operation_i;
      val_q     <= item_value_i;
      pos_q     <= position_i;
      res_rv_q  <= '0;
      res_fp_q  <= '0;
      res_mem_q <= 1'b0;
      res_st_q  <= ST_OK;
    end else begin
      if (cmd_i.rv_neg) begin
        res_rv_q <= '1;
      end else if (cmd_i.grab) begin
        res_rv_q <= rdata_q;
      end
      if (cmd_i.st_set) begin
        res_st_q <= cmd_i.st_val;
      end
      if (cmd_i.mem_hit) begin
        res_mem_q <= 1'b1;
      end
      if (cmd_i.fp_hit) begin
        res_fp_q <= hit32[FP_W-1:0];
      end else if (cmd_i.fp_miss) begin
        res_fp_q <= '1;
      end
    end
    if (cmd_i.out_load) begin
      out_rv_q  <= res_rv_q;
      out_fp_q  <= res_fp_q;
      out_mem_q <= res_mem_q;
      out_len_q <= cnt32[LEN_W-1:0];
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = out_rv_q;
  assign found_position_o = out_fp_q;
  assign is_member_o      = out_mem_q;
  assign entry_count_o    = out_len_q;
  assign status_o         = out_st_q;

endmodule

/* rtl/core/ile_ctrl.sv */
// Controller of the indexed list engine: sequences decode, entry shifts,
// scans and result delivery. Depends on ile_pkg.
module ile_ctrl import ile_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ile_stat_t stat_i,
  output ile_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_UP       = 4'd2;
  localparam logic [3:0] S_UP_DRAIN = 4'd3;
  localparam logic [3:0] S_PUT      = 4'd4;
  localparam logic [3:0] S_FETCH    = 4'd5;
  localparam logic [3:0] S_GRAB     = 4'd6;
  localparam logic [3:0] S_DN       = 4'd7;
  localparam logic [3:0] S_DN_DRAIN = 4'd8;
  localparam logic [3:0] S_SHRINK   = 4'd9;
  localparam logic [3:0] S_SCAN     = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.op) inside
          OP_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
          end
          OP_LENGTH: begin
          end
          OP_APPEND, OP_PREPEND, OP_INSERT: begin
            if (stat_i.op == OP_INSERT && stat_i.ins_bad) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = ST_RANGE;
            end else if (stat_i.full) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = ST_FULL;
            end else if (stat_i.at_end) begin
              state_d = S_PUT;
            end else begin
              cmd_o.rp_op = RP_TOP;
              state_d     = S_UP;
            end
          end
          OP_POP_BACK, OP_POP_FRONT, OP_REMOVE, OP_GET: begin
            if ((stat_i.op == OP_POP_BACK || stat_i.op == OP_POP_FRONT) ?
                stat_i.empty : stat_i.rem_bad) begin
              cmd_o.rv_neg = 1'b1;
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = ST_RANGE;
            end else begin
              cmd_o.rp_op = RP_IDX;
              state_d     = S_FETCH;
            end
          end
          OP_MEMBER, OP_FIND: begin
            cmd_o.rp_op = RP_ZERO;
            state_d     = S_SCAN;
          end
          default: begin
            cmd_o.rv_neg = 1'b1;
            cmd_o.st_set = 1'b1;
            cmd_o.st_val = ST_RANGE;
          end
        endcase
      end
      // Move entries one place up, from the top down to the target index
      S_UP: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rp_op   = RP_DEC;
        cmd_o.dir_up  = 1'b1;
        cmd_o.wr_pend = stat_i.pend;
        if (stat_i.rp_at_idx) begin
          state_d = S_UP_DRAIN;
        end
      end
      S_UP_DRAIN: begin
        cmd_o.dir_up  = 1'b1;
        cmd_o.wr_pend = 1'b1;
        state_d       = S_PUT;
      end
      S_PUT: begin
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_DONE;
      end
      S_FETCH: begin
        cmd_o.rd    = 1'b1;
        cmd_o.rp_op = RP_INC;
        state_d     = S_GRAB;
      end
      S_GRAB: begin
        cmd_o.grab = 1'b1;
        if (stat_i.op == OP_GET) begin
          state_d = S_DONE;
        end else if (stat_i.more) begin
          state_d = S_DN;
        end else begin
          state_d = S_SHRINK;
        end
      end
      // Close the gap: move later entries one place down
      S_DN: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rp_op   = RP_INC;
        cmd_o.wr_pend = stat_i.pend;
        if (stat_i.rp_next_end) begin
          state_d = S_DN_DRAIN;
        end
      end
      S_DN_DRAIN: begin
        cmd_o.wr_pend = 1'b1;
        state_d       = S_SHRINK;
      end
      S_SHRINK: begin
        cmd_o.cnt_dec = 1'b1;
        state_d       = S_DONE;
      end
      S_SCAN: begin
        if (stat_i.pend && stat_i.match) begin
          cmd_o.mem_hit = 1'b1;
          cmd_o.fp_hit  = (stat_i.op == OP_FIND);
          state_d       = S_DONE;
        end else if (stat_i.more) begin
          cmd_o.rd    = 1'b1;
          cmd_o.rp_op = RP_INC;
        end else if (!stat_i.pend) begin
          cmd_o.fp_miss = (stat_i.op == OP_FIND);
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/indexed_list_engine_core.sv */
// Indexed list engine: bounded ordered list of signed 32-bit values with
// 1-based positions. Top level; depends on ile_pkg, ile_ctrl and ile_dp.
//
// One request is taken at a time and gives exactly one result. Clear, length
// and rejected requests are answered straight from decode; appends and
// inserts at the end write the value directly, and a read at a position
// fetches one entry. Other inserts and prepends first move the later entries
// one place up; removals fetch the entry and, when later entries exist, move
// them one place down; member/find scan from the first entry up to the first
// match or the end of the list. The single-port entry memory with registered
// read moves or compares one entry per cycle, so shifts and scans grow with
// the number of entries they cover. A finished result waits in the output
// register while the next request is taken. There is no clearing pass after
// reset: only entries below the length are ever read.
module indexed_list_engine_core import ile_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  input  logic [POS_W-1:0]        position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] result_value_o,
  output logic signed [FP_W-1:0]  found_position_o,
  output logic                    is_member_o,
  output logic [LEN_W-1:0]        entry_count_o,
  output logic [ST_W-1:0]         status_o
);

  ile_cmd_t  cmd;
  ile_stat_t stat;

  ile_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ile_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .operation_i      (operation_i),
    .item_value_i     (item_value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_value_o   (result_value_o),
    .found_position_o (found_position_o),
    .is_member_o      (is_member_o),
    .entry_count_o    (entry_count_o),
    .status_o         (status_o)
  );

endmodule
